// ===== hdl/fbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types, codes and constants of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  // Chunk index space and field widths
  localparam int unsigned PoolDepth = 1024;
  localparam int unsigned IdxW      = 10;
  localparam int unsigned CntW      = 11;

  // Front command queue
  localparam int unsigned CmdQDepth = 2;
  localparam int unsigned CmdQPtrW  = 1;
  localparam int unsigned CmdQCntW  = 2;

  // Opcodes of an input transaction
  localparam logic [1:0] OpAlloc = 2'd0;
  localparam logic [1:0] OpFree  = 2'd1;
  localparam logic [1:0] OpClear = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CfgInitCap   = 2'd0;
  localparam logic [1:0] CfgGrowStep  = 2'd1;
  localparam logic [1:0] CfgGrowDbl   = 2'd2;

  localparam logic [CntW-1:0] InitCapReset  = 11'd16;
  localparam logic [CntW-1:0] GrowStepReset = 11'd0;
  localparam logic            GrowDblReset  = 1'b1;

  typedef enum logic [1:0] {
    CmdAlloc = 2'd0,
    CmdFree  = 2'd1,
    CmdClear = 2'd2,
    CmdNop   = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [IdxW-1:0] chunk_index;
  } req_t;

  typedef struct packed {
    logic            ok;
    logic [IdxW-1:0] granted_index;
    logic [CntW-1:0] previous_count;
    logic [CntW-1:0] count_in_use;
  } rsp_t;

  typedef struct packed {
    cmd_kind_e       kind;
    logic            idx_ok;
    logic [IdxW-1:0] chunk;
  } cmd_t;

  typedef struct packed {
    logic [CntW-1:0] initial_capacity;
    logic [CntW-1:0] grow_step;
    logic            grow_doubles;
  } cfg_t;

  // Clamp a capacity value to the chunk index space
  function automatic logic [CntW-1:0] sat_cap(logic [CntW-1:0] c);
    logic [CntW-1:0] r;
    if (32'(c) > PoolDepth) begin
      r = CntW'(PoolDepth);
    end else begin
      r = c;
    end
    return r;
  endfunction

  localparam logic [CntW-1:0] CapReset = sat_cap(InitCapReset);

endpackage

// ===== hdl/fbpa_ram.sv =====
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fbpa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/fbpa_front.sv =====
// ----------------------------------------------------------------------------
// fbpa_front
// Decode input transactions into commands and hold them in a short queue.
// ----------------------------------------------------------------------------
module fbpa_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  fbpa_pkg::req_t  req_i,
  output logic            cmd_valid_o,
  input  logic            cmd_pop_i,
  output fbpa_pkg::cmd_t  cmd_o
);

  fbpa_pkg::cmd_t                        entry_q [fbpa_pkg::CmdQDepth];
  logic [fbpa_pkg::CmdQPtrW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [fbpa_pkg::CmdQPtrW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [fbpa_pkg::CmdQCntW-1:0]         cnt_q, cnt_d;
  fbpa_pkg::cmd_t                        dec;
  logic                                  acc, deq;

  // Classify the opcode and range-check the chunk index
  always_comb begin
    dec.chunk  = req_i.chunk_index;
    dec.idx_ok = 32'(req_i.chunk_index) < fbpa_pkg::PoolDepth;
    unique case (req_i.opcode)
      fbpa_pkg::OpAlloc: dec.kind = fbpa_pkg::CmdAlloc;
      fbpa_pkg::OpFree:  dec.kind = fbpa_pkg::CmdFree;
      fbpa_pkg::OpClear: dec.kind = fbpa_pkg::CmdClear;
      default:           dec.kind = fbpa_pkg::CmdNop;
    endcase
  end

  assign full_o      = cnt_q == fbpa_pkg::CmdQCntW'(fbpa_pkg::CmdQDepth);
  assign cmd_valid_o = cnt_q != '0;
  assign cmd_o       = entry_q[rd_ptr_q];
  assign acc         = push_i && !full_o;
  assign deq         = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = acc ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = deq ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + fbpa_pkg::CmdQCntW'(acc) - fbpa_pkg::CmdQCntW'(deq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      entry_q[wr_ptr_q] <= dec;
    end
  end

endmodule

// ===== hdl/fbpa_back.sv =====
// ----------------------------------------------------------------------------
// fbpa_back
// Execute allocator commands against the pool state and the link store.
// ----------------------------------------------------------------------------
module fbpa_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fbpa_pkg::cfg_t  cfg_i,
  input  logic            cmd_valid_i,
  output logic            cmd_pop_o,
  input  fbpa_pkg::cmd_t  cmd_i,
  output logic            empty_o,
  input  logic            pop_i,
  output fbpa_pkg::rsp_t  rsp_o
);

  localparam logic StExec = 1'b0;
  localparam logic StLink = 1'b1;

  logic                          st_q, st_d;
  logic [fbpa_pkg::IdxW-1:0]     head_q, head_d;
  logic [fbpa_pkg::CntW-1:0]     bump_q, bump_d;
  logic [fbpa_pkg::CntW-1:0]     used_q, used_d;
  logic [fbpa_pkg::CntW-1:0]     cap_q, cap_d;
  fbpa_pkg::rsp_t                rsp_q, rsp_d;
  logic                          rsp_vld_q, rsp_vld_d;
  logic                          fire;
  logic [fbpa_pkg::CntW-1:0]     grow_add;
  logic [fbpa_pkg::CntW:0]       grow_sum;
  logic [fbpa_pkg::CntW-1:0]     grow_cap;
  logic                          grew, room;
  logic                          ram_we, ram_re;
  logic [fbpa_pkg::IdxW-1:0]     ram_rdata;

  fbpa_ram #(
    .Width (fbpa_pkg::IdxW),
    .Depth (fbpa_pkg::PoolDepth)
  ) u_link (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cmd_i.chunk),
    .wdata_i (head_q),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // Growth candidate, saturated at the pool depth
  always_comb begin
    grow_add = cfg_i.grow_doubles ? cap_q : cfg_i.grow_step;
    grow_sum = {1'b0, cap_q} + {1'b0, grow_add};
    if (32'(grow_sum) > fbpa_pkg::PoolDepth) begin
      grow_cap = fbpa_pkg::CntW'(fbpa_pkg::PoolDepth);
    end else begin
      grow_cap = grow_sum[fbpa_pkg::CntW-1:0];
    end
    grew = grow_cap > cap_q;
    room = (used_q < cap_q) || ((used_q == cap_q) && grew);
  end

  assign fire      = cmd_valid_i && (st_q == StExec) && (!rsp_vld_q || pop_i);
  assign cmd_pop_o = fire;

  always_comb begin
    st_d      = st_q;
    head_d    = head_q;
    bump_d    = bump_q;
    used_d    = used_q;
    cap_d     = cap_q;
    rsp_d     = rsp_q;
    rsp_vld_d = rsp_vld_q && !pop_i;
    ram_we    = 1'b0;
    ram_re    = 1'b0;

    if (st_q == StLink) begin
      // finish the free-list pop
      head_d = ram_rdata;
      st_d   = StExec;
    end

    if (fire) begin
      rsp_vld_d            = 1'b1;
      rsp_d.ok             = 1'b0;
      rsp_d.granted_index  = '0;
      rsp_d.previous_count = '0;
      unique case (cmd_i.kind)
        fbpa_pkg::CmdAlloc: begin
          if (room) begin
            if (used_q == cap_q) begin
              cap_d = grow_cap;
            end
            if (used_q == bump_q) begin
              rsp_d.granted_index = bump_q[fbpa_pkg::IdxW-1:0];
              bump_d              = bump_q + fbpa_pkg::CntW'(1);
            end else begin
              rsp_d.granted_index = head_q;
              ram_re              = 1'b1;
              st_d                = StLink;
            end
            used_d   = used_q + fbpa_pkg::CntW'(1);
            rsp_d.ok = 1'b1;
          end
        end
        fbpa_pkg::CmdFree: begin
          if ((used_q != '0) && cmd_i.idx_ok) begin
            ram_we   = 1'b1;
            head_d   = cmd_i.chunk;
            used_d   = used_q - fbpa_pkg::CntW'(1);
            rsp_d.ok = 1'b1;
          end
        end
        fbpa_pkg::CmdClear: begin
          rsp_d.previous_count = used_q;
          used_d               = '0;
          bump_d               = '0;
          head_d               = '0;
          cap_d                = fbpa_pkg::sat_cap(cfg_i.initial_capacity);
          rsp_d.ok             = 1'b1;
        end
        default: begin
        end
      endcase
      rsp_d.count_in_use = used_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StExec;
      head_q    <= '0;
      bump_q    <= '0;
      used_q    <= '0;
      cap_q     <= fbpa_pkg::CapReset;
      rsp_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      head_q    <= head_d;
      bump_q    <= bump_d;
      used_q    <= used_d;
      cap_q     <= cap_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign empty_o = !rsp_vld_q;
  assign rsp_o   = rsp_q;

endmodule

// ===== hdl/fixed_block_pool_allocator_core.sv =====
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core
// Fixed-size block allocator: bump mark plus LIFO free list over 1024 chunks.
// ----------------------------------------------------------------------------
//
// Channel   Handshake            Payload        Accepted when
// -------   ------------------   ------------   ------------------------
// request   push / full          req_i (req_t)  push && !full
// result    empty / pop          rsp_o (rsp_t)  pop && !empty
// config    cfg_we_i             cfg_addr_i,    cfg_we_i
//                                cfg_wdata_i
//
// Execution: each command is executed by the engine; an allocate served
// from the free list also passes through the link state, since the next
// list head comes from a registered read of the link store. A transaction
// is written into the registered command queue before it executes.
// Reset: control state clears at once; the link store is not cleared, and
// the free list only ever reads entries written by an earlier free.
// Stalls: a waiting result holds the engine only; the command queue keeps
// taking requests until it fills.
//
module fixed_block_pool_allocator_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  fbpa_pkg::req_t                req_i,
  output logic                          empty,
  input  logic                          pop,
  output fbpa_pkg::rsp_t                rsp_o,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_addr_i,
  input  logic [fbpa_pkg::CntW-1:0]     cfg_wdata_i
);

  fbpa_pkg::cfg_t cfg_q;
  fbpa_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_pop;

  // Configuration registers; a write to an unused index is dropped.
  // New values act only at the next clear or growth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.initial_capacity <= fbpa_pkg::InitCapReset;
      cfg_q.grow_step        <= fbpa_pkg::GrowStepReset;
      cfg_q.grow_doubles     <= fbpa_pkg::GrowDblReset;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        fbpa_pkg::CfgInitCap:  cfg_q.initial_capacity <= cfg_wdata_i;
        fbpa_pkg::CfgGrowStep: cfg_q.grow_step        <= cfg_wdata_i;
        fbpa_pkg::CfgGrowDbl:  cfg_q.grow_doubles     <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // Front: decode each request transaction and queue it
  fbpa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  // Back: advance the pool state and present one result per command
  fbpa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .empty_o     (empty),
    .pop_i       (pop),
    .rsp_o       (rsp_o)
  );

endmodule

// ===== hdl/fbpa_checker.sv =====
// ----------------------------------------------------------------------------
// fbpa_checker
// Port-level checks of the pool allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fbpa_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          full,
  input  logic                          empty,
  input  logic                          pop,
  input  fbpa_pkg::rsp_t                rsp_o
);

  // Reset leaves no result and room for requests
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> empty && !full)
    else $error("results or full flag present after reset");

  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(rsp_o))
    else $error("stalled result changed");

  // The in-use count never exceeds the pool depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> 32'(rsp_o.count_in_use) <= fbpa_pkg::PoolDepth)
    else $error("count_in_use beyond pool depth");

  // A nonzero previous count comes only from a clear
  a_clear_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && rsp_o.previous_count != '0 |->
      rsp_o.ok && rsp_o.count_in_use == '0 && rsp_o.granted_index == '0)
    else $error("malformed clear result");

  // A failed transaction reports no chunk and no previous count
  a_fail_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !rsp_o.ok |-> rsp_o.granted_index == '0 && rsp_o.previous_count == '0)
    else $error("failed result carries data");

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (.*);

// ===== tb/sv/fixed_block_pool_allocator_core_test.sv =====
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core_test
// Self-checking bench for the block pool allocator. A scoreboard predicts the
// response to every accepted request (bump grants, free-list pops, growth and
// clears) and checks each popped response against the oldest prediction,
// while both queue ports idle in random bursts across several register setups.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_core_test;
  import fbpa_pkg::*;

  localparam logic [1:0] OpIgnored  = 2'(CmdNop);
  localparam int         CycleLimit = 400000;
  localparam int         FillAllocs = 1030;

  typedef enum int {
    GenScript,
    GenMixed,
    GenFill
  } gen_mode_e;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow copy of the allocator plus the responses still owed.
  // --------------------------------------------------------------------------
  class pool_scoreboard;
    logic [CntW-1:0] init_cap;
    logic [CntW-1:0] grow_step;
    logic            grow_dbl;
    logic [IdxW-1:0] link_mem [PoolDepth];
    logic [IdxW-1:0] head;
    logic [CntW-1:0] bump;
    logic [CntW-1:0] in_use;
    logic [CntW-1:0] cap;
    logic [IdxW-1:0] held_chunks [$];
    rsp_t            rsp_due [$];
    int              mismatches;

    function new();
      init_cap  = InitCapReset;
      grow_step = GrowStepReset;
      grow_dbl  = GrowDblReset;
      foreach (link_mem[i]) link_mem[i] = '0;
      head       = '0;
      bump       = '0;
      in_use     = '0;
      cap        = start_capacity();
      mismatches = 0;
    endfunction

    function logic [CntW-1:0] start_capacity();
      return (int'(init_cap) > int'(PoolDepth)) ? CntW'(PoolDepth) : init_cap;
    endfunction

    function void set_reg(logic [1:0] addr, logic [CntW-1:0] value);
      case (addr)
        CfgInitCap:  init_cap  = value;
        CfgGrowStep: grow_step = value;
        CfgGrowDbl:  grow_dbl  = value[0];
        default: ;
      endcase
    endfunction

    // Advance the shadow state by one accepted request and queue its response.
    function void note_request(req_t item);
      rsp_t        r;
      logic        room;
      int unsigned add;
      int unsigned grown;
      r = '0;
      case (item.opcode)
        OpAlloc: begin
          room = (in_use < cap);
          if (!room && in_use == cap) begin
            add   = grow_dbl ? int'(cap) : int'(grow_step);
            grown = int'(cap) + add;
            if (grown > PoolDepth) grown = PoolDepth;
            if (grown > int'(cap)) begin
              cap  = CntW'(grown);
              room = 1'b1;
            end
          end
          if (room) begin
            if (in_use == bump) begin
              r.granted_index = bump[IdxW-1:0];
              bump++;
            end else begin
              r.granted_index = head;
              head = link_mem[head];
            end
            in_use++;
            r.ok = 1'b1;
            held_chunks.push_back(r.granted_index);
          end
        end
        OpFree: begin
          if (in_use != 0) begin
            link_mem[item.chunk_index] = head;
            head = item.chunk_index;
            in_use--;
            r.ok = 1'b1;
            foreach (held_chunks[i]) begin
              if (held_chunks[i] == item.chunk_index) begin
                held_chunks.delete(i);
                break;
              end
            end
          end
        end
        OpClear: begin
          r.previous_count = in_use;
          in_use = '0;
          bump   = '0;
          head   = '0;
          cap    = start_capacity();
          r.ok   = 1'b1;
          held_chunks.delete();
        end
        default: ;
      endcase
      r.count_in_use = in_use;
      rsp_due.push_back(r);
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (rsp_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected response: ok=%0d grant=%0d prev=%0d count=%0d",
                   got.ok, got.granted_index, got.previous_count, got.count_in_use);
        return;
      end
      want = rsp_due.pop_front();
      if (got.ok !== want.ok || got.granted_index !== want.granted_index ||
          got.previous_count !== want.previous_count ||
          got.count_in_use !== want.count_in_use) begin
        mismatches++;
        if (mismatches <= 10)
          $display("response mismatch: expected ok=%0d grant=%0d prev=%0d count=%0d, %s",
                   want.ok, want.granted_index, want.previous_count, want.count_in_use,
                   $sformatf("got ok=%0d grant=%0d prev=%0d count=%0d", got.ok,
                             got.granted_index, got.previous_count, got.count_in_use));
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block hookup; every input starts at a known value.
  // --------------------------------------------------------------------------
  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            push        = 1'b0;
  req_t            req_i       = '0;
  logic            pop         = 1'b0;
  logic            cfg_we_i    = 1'b0;
  logic [1:0]      cfg_addr_i  = '0;
  logic [CntW-1:0] cfg_wdata_i = '0;
  logic            full;
  logic            empty;
  rsp_t            rsp_o;

  fixed_block_pool_allocator_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_i       (req_i),
    .empty       (empty),
    .pop         (pop),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  pool_scoreboard sb;
  req_t           script_q [$];
  bit             tx_idle_on = 1'b1;
  bit             rx_idle_on = 1'b1;
  int             rx_gap     = 0;
  int             cycle_count = 0;

  // Watchdog: end the run as failed if it is still going at the cycle limit.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // Response side: check every popped transaction, then pick the next pop
  // level. Stalls come in bursts so that they land on every engine cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) sb.check_result(rsp_o);
      if (rx_gap > 0) begin
        rx_gap--;
        pop <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 11) == 0) begin
        rx_gap = $urandom_range(0, 14);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic void add_step(logic [1:0] op, logic [IdxW-1:0] idx);
    req_t item;
    item.opcode      = op;
    item.chunk_index = idx;
    script_q.push_back(item);
  endfunction

  // Build the next request. Random phases open with a clear so that the new
  // register values are loaded; frees mostly return a chunk still held.
  function automatic req_t next_item(gen_mode_e mode, int pos);
    req_t item;
    int   r;
    if (mode == GenScript) return script_q.pop_front();
    r = $urandom_range(0, 99);
    item.chunk_index = IdxW'($urandom_range(0, PoolDepth - 1));
    if (pos == 0) item.opcode = OpClear;
    else if (mode == GenFill && pos < FillAllocs) item.opcode = OpAlloc;
    else if (r < 62) item.opcode = OpAlloc;
    else if (r < 97) item.opcode = OpFree;
    else if (r < 98) item.opcode = OpClear;
    else item.opcode = OpIgnored;
    if (item.opcode == OpFree && sb.held_chunks.size() != 0 && $urandom_range(0, 6) != 0)
      item.chunk_index = sb.held_chunks[$urandom_range(0, sb.held_chunks.size() - 1)];
    return item;
  endfunction

  // Request side: offer n transactions, holding each one while full is high
  // and dropping push for random idle bursts between them.
  task automatic send_items(int n, gen_mode_e mode);
    int sent;
    int gap;
    sent = 0;
    gap  = 0;
    while (sent < n) begin
      @(posedge clk_i);
      if (push && !full) begin
        sb.note_request(req_i);
        sent++;
      end
      if (sent == n) begin
        push <= 1'b0;
      end else if (!(push && full)) begin
        if (gap > 0) begin
          gap--;
          push <= 1'b0;
        end else if (tx_idle_on && $urandom_range(0, 11) == 0) begin
          gap = $urandom_range(0, 14);
          push <= 1'b0;
        end else begin
          req_i <= next_item(mode, sent);
          push  <= 1'b1;
        end
      end
    end
  endtask

  // Wait for every owed response, give the engine a few spare cycles, then
  // load all three registers.
  task automatic load_regs(logic [CntW-1:0] init_cap, logic [CntW-1:0] step, logic dbl);
    logic [1:0]      addrs [3];
    logic [CntW-1:0] vals [3];
    addrs = '{CfgInitCap, CfgGrowStep, CfgGrowDbl};
    vals  = '{init_cap, step, CntW'(dbl)};
    while (sb.rsp_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    for (int i = 0; i < 3; i++) begin
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= addrs[i];
      cfg_wdata_i <= vals[i];
      sb.set_reg(addrs[i], vals[i]);
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(logic [CntW-1:0] init_cap, logic [CntW-1:0] step, logic dbl,
                           int n, gen_mode_e mode, bit idle);
    load_regs(init_cap, step, dbl);
    tx_idle_on = idle;
    rx_idle_on = idle;
    send_items(n, mode);
  endtask

  task automatic run_script();
    send_items(script_q.size(), GenScript);
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Reset setup: free on an empty pool, ignored opcode, bump grants, a free-list
    // pop, a free of a chunk never handed out, a clear, then a free on the emptied pool.
    add_step(OpFree,    10'h3FF);
    add_step(OpIgnored, 10'h3FF);
    add_step(OpAlloc,   10'h3FF);
    add_step(OpAlloc,   10'h000);
    add_step(OpFree,    10'h000);
    add_step(OpAlloc,   10'h155);
    add_step(OpFree,    10'h3FF);
    add_step(OpAlloc,   10'h2AA);
    add_step(OpAlloc,   10'h000);
    add_step(OpClear,   10'h3FF);
    add_step(OpFree,    10'h005);
    run_script();

    // Capacity of one without growth: the second allocate must fail.
    load_regs(11'd1, 11'd0, 1'b0);
    add_step(OpClear, 10'h000);
    add_step(OpAlloc, 10'h000);
    add_step(OpAlloc, 10'h000);
    add_step(OpFree,  10'h000);
    add_step(OpAlloc, 10'h000);
    run_script();

    // Zero capacity: doubling cannot lift it, a step to the full depth can.
    load_regs(11'd0, 11'd0, 1'b1);
    add_step(OpClear, 10'h000);
    add_step(OpAlloc, 10'h000);
    run_script();
    load_regs(11'd0, 11'd1024, 1'b0);
    add_step(OpAlloc, 10'h000);
    add_step(OpClear, 10'h000);
    run_script();

    // Random phases across register setups.
    run_phase(11'd16, 11'd0, 1'b1, 150, GenMixed, 1'b1);
    run_phase(11'd1, 11'd0, 1'b0, 120, GenMixed, 1'b1);
    run_phase(11'd3, CntW'($urandom_range(1, 7)), 1'b0, 120, GenMixed, 1'b1);
    run_phase(11'd0, 11'd1, 1'b0, 100, GenMixed, 1'b0);
    // Oversized initial capacity saturates at the depth; fill the whole pool
    // so that doubling saturates and the allocates past it fail.
    run_phase(11'd2047, 11'd1024, 1'b1, 1040, GenFill, 1'b1);
    for (int p = 0; p < 3; p++) begin
      run_phase(CntW'($urandom_range(1, 1024)), CntW'($urandom_range(0, 1024)),
                1'($urandom_range(0, 1)), 60, GenMixed, p != 2);
    end

    // Drain, leave room for any stray response, then report.
    while (sb.rsp_due.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (sb.rsp_due.size() != 0) begin
      $display("%0d responses never arrived", sb.rsp_due.size());
      sb.mismatches += sb.rsp_due.size();
    end
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
